[rtl/ssad_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssad_pkg
// Shared widths, status codes and operation codes of the sparse set block.
// ----------------------------------------------------------------------------
package ssad_pkg;

	localparam int ID_W                 = 10;
	localparam int STATUS_W             = 2;
	localparam int COUNT_OUT_W          = 11;
	localparam int DEFAULT_MAX_ENTITIES = 1024;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SAME = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	localparam logic FUNC_ATTACH = 1'b0;
	localparam logic FUNC_DETACH = 1'b1;

endpackage
`default_nettype wire

[rtl/ssad_dense_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssad_dense_ram
// Dense list of member ids, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ssad_dense_ram #(
	parameter int DEPTH  = ssad_pkg::DEFAULT_MAX_ENTITIES,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = ssad_pkg::ID_W
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/ssad_map_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssad_map_ram
// Id-to-slot map holding {present, slot} per id, cleared by a sweep after
// reset, one entry a cycle.
// ----------------------------------------------------------------------------
module ssad_map_ram #(
	parameter int DEPTH  = ssad_pkg::DEFAULT_MAX_ENTITIES,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = ADDR_W + 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata,
	output logic                   busy
);

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [ADDR_W-1:0] clr_q;
	logic              busy_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [DATA_W-1:0] mem_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == LAST_ADDR) begin
				busy_q <= 1'b0;
			end
		end
	end

	// sweep owns the write port until done
	always_comb begin
		mem_we    = busy_q | we;
		mem_waddr = busy_q ? clr_q : waddr;
		mem_wdata = busy_q ? '0 : wdata;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

[rtl/sparse_set_attach_detach.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_set_attach_detach
// Sparse set with attach and detach, kept in an id-to-slot map memory and a
// dense id list memory.
// ----------------------------------------------------------------------------
// One word is taken at a time. Attach, and any failed operation, go from
// accept to the next accept through the id-to-slot map read, then the
// update. A detach that moves the last member into the freed slot adds a
// dense list read in between, since that read depends on the map read.
// in_ready also drops while a result is computed and the output register
// still holds an untaken word. After reset the map is swept clean over all
// MAX_ENTITIES entries and no word is accepted before the sweep ends.
module sparse_set_attach_detach #(
	parameter int MAX_ENTITIES = ssad_pkg::DEFAULT_MAX_ENTITIES
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             func,
	input  wire logic [ssad_pkg::ID_W-1:0]        entity_id,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [ssad_pkg::STATUS_W-1:0]    status,
	output logic      [ssad_pkg::ID_W-1:0]        slot,
	output logic                                  moved,
	output logic      [ssad_pkg::ID_W-1:0]        moved_from,
	output logic      [ssad_pkg::ID_W-1:0]        moved_entity,
	output logic      [ssad_pkg::COUNT_OUT_W-1:0] member_count
);
	import ssad_pkg::*;

	localparam int SLOT_W  = $clog2(MAX_ENTITIES);
	localparam int MAP_W   = SLOT_W + 1;
	localparam int COUNT_W = $clog2(MAX_ENTITIES + 1);
	localparam int CMP_W   = ((SLOT_W > ID_W) ? SLOT_W : ID_W) + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD1  = 2'd1;
	localparam logic [1:0] S_RD2  = 2'd2;

	logic [1:0]         state_q;
	logic               func_q;
	logic [ID_W-1:0]    id_q;
	logic [SLOT_W-1:0]  idx_q;
	logic               ok_q;
	logic [COUNT_W-1:0] count_q;
	logic [SLOT_W-1:0]  freed_q;
	logic [SLOT_W-1:0]  last_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     slot_q;
	logic                moved_q;
	logic [ID_W-1:0]     from_q;
	logic [ID_W-1:0]     ent_q;

	logic [CMP_W-1:0]   id_ext;
	logic               accept;
	logic               out_free;
	logic               clr_busy;

	logic               map_we;
	logic [SLOT_W-1:0]  map_waddr;
	logic [MAP_W-1:0]   map_wdata;
	logic [MAP_W-1:0]   map_rdata;
	logic               dense_we;
	logic [SLOT_W-1:0]  dense_waddr;
	logic [ID_W-1:0]    dense_wdata;
	logic               dense_re;
	logic [ID_W-1:0]    dense_rdata;

	logic               present;
	logic [SLOT_W-1:0]  mslot;
	logic [SLOT_W-1:0]  last_slot;

	logic               fin;
	logic               go2;
	logic               cnt_we;
	logic [COUNT_W-1:0] cnt_next;
	logic [STATUS_W-1:0] res_status;
	logic [ID_W-1:0]     res_slot;
	logic                res_moved;
	logic [ID_W-1:0]     res_from;
	logic [ID_W-1:0]     res_ent;
	logic                load_out;

	assign id_ext   = CMP_W'(entity_id);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && !clr_busy;
	assign accept   = in_valid && in_ready;

	assign present   = map_rdata[SLOT_W];
	assign mslot     = map_rdata[SLOT_W-1:0];
	assign last_slot = SLOT_W'(count_q - 1'b1);

	always_comb begin
		fin         = 1'b0;
		go2         = 1'b0;
		cnt_we      = 1'b0;
		cnt_next    = count_q;
		map_we      = 1'b0;
		map_waddr   = idx_q;
		map_wdata   = '0;
		dense_we    = 1'b0;
		dense_waddr = freed_q;
		dense_wdata = dense_rdata;
		dense_re    = 1'b0;
		res_status  = ST_SAME;
		res_slot    = '0;
		res_moved   = 1'b0;
		res_from    = '0;
		res_ent     = '0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_RD1: begin
				if (func_q == FUNC_ATTACH) begin
					fin = 1'b1;
					if (ok_q && present) begin
						res_status = ST_SAME;
					end else if (!ok_q || count_q >= COUNT_W'(MAX_ENTITIES)) begin
						res_status = ST_FULL;
					end else begin
						res_status  = ST_DONE;
						res_slot    = ID_W'(count_q[SLOT_W-1:0]);
						map_we      = out_free;
						map_wdata   = {1'b1, count_q[SLOT_W-1:0]};
						dense_we    = out_free;
						dense_waddr = count_q[SLOT_W-1:0];
						dense_wdata = id_q;
						cnt_we      = out_free;
						cnt_next    = count_q + 1'b1;
					end
				end else begin
					if (!ok_q || !present || count_q == '0) begin
						fin        = 1'b1;
						res_status = ST_SAME;
					end else if (mslot == last_slot) begin
						// the last member itself leaves, nothing moves
						fin        = 1'b1;
						res_status = ST_DONE;
						res_slot   = ID_W'(mslot);
						map_we     = out_free;
						map_wdata  = {1'b0, mslot};
						cnt_we     = out_free;
						cnt_next   = COUNT_W'(last_slot);
					end else begin
						go2       = 1'b1;
						map_we    = 1'b1;
						map_wdata = {1'b0, mslot};
						dense_re  = 1'b1;
					end
				end
			end
			S_RD2: begin
				// last member goes into the freed slot
				fin         = 1'b1;
				res_status  = ST_DONE;
				res_slot    = ID_W'(freed_q);
				res_moved   = 1'b1;
				res_from    = ID_W'(last_q);
				res_ent     = dense_rdata;
				map_we      = out_free;
				map_waddr   = SLOT_W'(dense_rdata);
				map_wdata   = {1'b1, freed_q};
				dense_we    = out_free;
				dense_waddr = freed_q;
				dense_wdata = dense_rdata;
				cnt_we      = out_free;
				cnt_next    = COUNT_W'(last_q);
			end
			default: begin
			end
		endcase
	end

	assign load_out = fin && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= S_RD1;
			end else if (go2) begin
				state_q <= S_RD2;
			end else if (load_out) begin
				state_q <= S_IDLE;
			end
			if (cnt_we) begin
				count_q <= cnt_next;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			id_q   <= entity_id;
			idx_q  <= id_ext[SLOT_W-1:0];
			ok_q   <= id_ext < CMP_W'(MAX_ENTITIES);
		end
		if (go2) begin
			freed_q <= mslot;
			last_q  <= last_slot;
		end
		if (load_out) begin
			status_q <= res_status;
			slot_q   <= res_slot;
			moved_q  <= res_moved;
			from_q   <= res_from;
			ent_q    <= res_ent;
		end
	end

	ssad_map_ram #(
		.DEPTH  (MAX_ENTITIES),
		.ADDR_W (SLOT_W),
		.DATA_W (MAP_W)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (map_we),
		.waddr  (map_waddr),
		.wdata  (map_wdata),
		.re     (accept),
		.raddr  (id_ext[SLOT_W-1:0]),
		.rdata  (map_rdata),
		.busy   (clr_busy)
	);

	ssad_dense_ram #(
		.DEPTH  (MAX_ENTITIES),
		.ADDR_W (SLOT_W),
		.DATA_W (ID_W)
	) u_dense (
		.clk    (clk),
		.we     (dense_we),
		.waddr  (dense_waddr),
		.wdata  (dense_wdata),
		.re     (dense_re),
		.raddr  (last_slot),
		.rdata  (dense_rdata)
	);

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign slot         = slot_q;
	assign moved        = moved_q;
	assign moved_from   = from_q;
	assign moved_entity = ent_q;
	assign member_count = COUNT_OUT_W'(count_q);

`ifndef NO_ASSERTIONS
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !in_ready)
		else $error("word accepted during map sweep");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(MAX_ENTITIES))
		else $error("member count above capacity");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_RD1))
		else $error("accepted word did not start a map read");

	a_moved_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && moved) |-> (status == ST_DONE))
		else $error("move reported on a failed operation");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_DONE) |-> (slot == '0 && !moved))
		else $error("failed operation carries slot or move");
`endif

endmodule
`default_nettype wire
